>>> design/congestion_window_controller_assert.svh
`ifndef CONGESTION_WINDOW_CONTROLLER_ASSERT_SVH
`define CONGESTION_WINDOW_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked on i_clk, off while i_rst_n is low
`define CWC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk, off while i_rst_n is low
`define CWC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/cwc_pkg.sv
package cwc_pkg;

    // window and sequence geometry
    localparam int MAX_WINDOW = 32;
    localparam int SEQ_W      = 16;
    localparam int SLOT_W     = SEQ_W + 1;
    localparam int WIN_W      = 6;
    localparam int DUP_W      = 4;
    localparam int MODE_W     = 2;
    localparam int ACT_W      = 2;

    // apb geometry
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [DUP_W-1:0] DUP_SAT = '1;

    // event kinds
    localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;

    // result actions
    localparam logic [ACT_W-1:0] ACT_SEND     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RESEND   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPLETE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE     = 2'd3;

    // register indexes
    localparam logic [1:0] REG_INIT_WINDOW    = 2'd0;
    localparam logic [1:0] REG_INIT_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_DUP_ACK_LIMIT  = 2'd2;
    localparam logic [1:0] REG_TOTAL_SEGMENTS = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        RUN_SEND,
        RUN_RESEND,
        RUN_COMPLETE,
        RUN_NONE
    } t_run;

    typedef struct packed {
        logic [WIN_W-1:0] init_window;
        logic [WIN_W-1:0] init_threshold;
        logic [DUP_W-1:0] dup_ack_limit;
        logic [SEQ_W-1:0] total_segments;
    } t_cfg;

    typedef struct packed {
        logic cap_in;
        logic decide;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic beat_last;
        logic beat_real;
    } t_sts;

    // clamp a window value to the largest allowed window
    function automatic logic [WIN_W-1:0] sat_win(input logic [WIN_W:0] v);
        logic [WIN_W-1:0] res;
        if (v > (WIN_W + 1)'(MAX_WINDOW)) begin
            res = WIN_W'(MAX_WINDOW);
        end else begin
            res = v[WIN_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> design/cwc_if.sv
// event channel
interface cwc_evt_if;
    logic                            valid;
    logic                            ready;
    logic [cwc_pkg::MODE_W-1:0]      mode;
    logic [cwc_pkg::SEQ_W-1:0]       ack_number;

    modport source (output valid, output mode, output ack_number, input ready);
    modport sink   (input valid, input mode, input ack_number, output ready);
endinterface

// command channel
interface cwc_res_if;
    logic                            valid;
    logic                            ready;
    logic [cwc_pkg::ACT_W-1:0]       action;
    logic [cwc_pkg::SEQ_W-1:0]       seq_number;
    logic [cwc_pkg::WIN_W-1:0]       window_now;
    logic [cwc_pkg::WIN_W-1:0]       threshold_now;
    logic                            last_of_run;

    modport source (output valid, output action, output seq_number, output window_now,
                    output threshold_now, output last_of_run, input ready);
    modport sink   (input valid, input action, input seq_number, input window_now,
                    input threshold_now, input last_of_run, output ready);
endinterface

>>> design/cwc_dpath.sv
`include "congestion_window_controller_assert.svh"

module cwc_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cwc_pkg::t_cfg                 i_cfg,
    input  cwc_pkg::t_cmd                 i_cmd,
    input  logic [cwc_pkg::MODE_W-1:0]    i_mode,
    input  logic [cwc_pkg::SEQ_W-1:0]     i_ack_number,
    output cwc_pkg::t_sts                 o_sts,
    output logic [cwc_pkg::ACT_W-1:0]     o_action,
    output logic [cwc_pkg::SEQ_W-1:0]     o_seq_number,
    output logic [cwc_pkg::WIN_W-1:0]     o_window_now,
    output logic [cwc_pkg::WIN_W-1:0]     o_threshold_now,
    output logic                          o_last_of_run
);

    // connection state
    logic [cwc_pkg::SEQ_W-1:0]  r_acked, n_acked;
    logic [cwc_pkg::SEQ_W-1:0]  r_oldest, n_oldest;
    logic [cwc_pkg::SLOT_W-1:0] r_slot, n_slot;
    logic [cwc_pkg::WIN_W-1:0]  r_window, n_window;
    logic [cwc_pkg::WIN_W-1:0]  r_thresh, n_thresh;
    logic [cwc_pkg::SEQ_W-1:0]  r_growth, n_growth;
    logic [cwc_pkg::DUP_W-1:0]  r_dup_cnt, n_dup_cnt;
    logic [cwc_pkg::SEQ_W-1:0]  r_dup_val, n_dup_val;
    logic [cwc_pkg::SEQ_W-1:0]  r_hs, n_hs;
    logic                       r_sd, n_sd;

    // latched event
    logic [cwc_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [cwc_pkg::SEQ_W-1:0]  r_ack, n_ack;

    // run sequencer
    cwc_pkg::t_run              r_run, n_run;
    logic [cwc_pkg::SEQ_W-1:0]  r_done_seq, n_done_seq;
    logic [cwc_pkg::SEQ_W-1:0]  r_rs_seq, n_rs_seq;
    logic [cwc_pkg::WIN_W-1:0]  r_rs_cnt, n_rs_cnt;
    logic [cwc_pkg::WIN_W-1:0]  r_rs_lim, n_rs_lim;

    // output beat
    logic [cwc_pkg::ACT_W-1:0]  r_out_action, n_out_action;
    logic [cwc_pkg::SEQ_W-1:0]  r_out_seq, n_out_seq;
    logic [cwc_pkg::WIN_W-1:0]  r_out_win, n_out_win;
    logic [cwc_pkg::WIN_W-1:0]  r_out_thr, n_out_thr;
    logic                       r_out_last, n_out_last;

    // decision terms
    logic [cwc_pkg::SEQ_W-1:0]  tot;
    logic                       active;
    logic [cwc_pkg::WIN_W-1:0]  start_win;
    logic [cwc_pkg::WIN_W-1:0]  start_thr;
    logic [cwc_pkg::DUP_W-1:0]  dup_lim;
    logic [cwc_pkg::DUP_W-1:0]  dup_next;
    logic [cwc_pkg::WIN_W-1:0]  half_win;
    logic [cwc_pkg::WIN_W-1:0]  fr_win;
    logic                       grow;
    logic [cwc_pkg::WIN_W-1:0]  grown_win;
    logic [cwc_pkg::WIN_W-1:0]  ack_win;
    logic [cwc_pkg::SEQ_W-1:0]  since_mark;

    // beat terms
    logic [cwc_pkg::SLOT_W-1:0] hs_inc;
    logic [cwc_pkg::SLOT_W-1:0] hs_after;
    logic                       send_cond;
    logic                       send_next;
    logic [cwc_pkg::SLOT_W-1:0] rs_inc;
    logic [cwc_pkg::WIN_W-1:0]  rs_cnt_inc;
    logic                       rs_cond;
    logic                       rs_next;
    logic [cwc_pkg::ACT_W-1:0]  beat_action;
    logic [cwc_pkg::SEQ_W-1:0]  beat_seq;
    logic                       beat_last;
    logic                       beat_real;

    // configuration after range fixes
    assign tot       = i_cfg.total_segments;
    assign active    = (r_slot != '0);
    assign start_win = cwc_pkg::sat_win({1'b0, (i_cfg.init_window == '0) ?
                                          cwc_pkg::WIN_W'(1) : i_cfg.init_window});
    assign start_thr = cwc_pkg::sat_win({1'b0, i_cfg.init_threshold});
    assign dup_lim   = (i_cfg.dup_ack_limit == '0) ? cwc_pkg::DUP_W'(1) : i_cfg.dup_ack_limit;

    // duplicate ack count, restarting on a new value
    always_comb begin
        if (r_ack == r_dup_val) begin
            dup_next = (r_dup_cnt == cwc_pkg::DUP_SAT) ? cwc_pkg::DUP_SAT
                                                       : r_dup_cnt + cwc_pkg::DUP_W'(1);
        end else begin
            dup_next = cwc_pkg::DUP_W'(1);
        end
    end

    // window arithmetic
    assign half_win   = r_window >> 1;
    assign fr_win     = cwc_pkg::sat_win({1'b0, half_win} + (cwc_pkg::WIN_W + 1)'(3));
    assign since_mark = r_ack - r_growth;
    assign grow       = !r_sd && (since_mark >= cwc_pkg::SEQ_W'(r_window));
    assign grown_win  = (r_window < r_thresh) ? cwc_pkg::sat_win({r_window, 1'b0})
                      : cwc_pkg::sat_win({1'b0, r_window} + (cwc_pkg::WIN_W + 1)'(1));
    assign ack_win    = grow ? grown_win : r_window;

    // send and retransmit run conditions with one-step lookahead
    assign hs_inc     = {1'b0, r_hs} + cwc_pkg::SLOT_W'(1);
    assign send_cond  = (r_hs < tot) && ({1'b0, r_hs} < r_slot);
    assign send_next  = (hs_inc < {1'b0, tot}) && (hs_inc < r_slot);
    assign hs_after   = send_cond ? hs_inc : {1'b0, r_hs};
    assign rs_inc     = {1'b0, r_rs_seq} + cwc_pkg::SLOT_W'(1);
    assign rs_cnt_inc = r_rs_cnt + cwc_pkg::WIN_W'(1);
    assign rs_cond    = (r_rs_seq <= r_hs) && (r_rs_cnt < r_rs_lim);
    assign rs_next    = (rs_inc <= {1'b0, r_hs}) && (rs_cnt_inc < r_rs_lim);

    // current beat of the run
    always_comb begin
        beat_action = cwc_pkg::ACT_NONE;
        beat_seq    = '0;
        beat_last   = 1'b1;
        beat_real   = 1'b0;
        case (r_run)
            cwc_pkg::RUN_SEND: begin
                if (send_cond) begin
                    beat_action = cwc_pkg::ACT_SEND;
                    beat_seq    = hs_inc[cwc_pkg::SEQ_W-1:0];
                    beat_last   = !send_next;
                    beat_real   = 1'b1;
                end
            end
            cwc_pkg::RUN_RESEND: begin
                if (rs_cond) begin
                    beat_action = cwc_pkg::ACT_RESEND;
                    beat_seq    = r_rs_seq;
                    beat_last   = !rs_next;
                    beat_real   = 1'b1;
                end
            end
            cwc_pkg::RUN_COMPLETE: begin
                beat_action = cwc_pkg::ACT_COMPLETE;
                beat_seq    = r_done_seq;
                beat_real   = 1'b1;
            end
            default: begin
                beat_action = cwc_pkg::ACT_NONE;
            end
        endcase
    end

    assign o_sts.beat_last = beat_last;
    assign o_sts.beat_real = beat_real;

    // next state for capture, decision and run steps
    always_comb begin
        n_acked      = r_acked;
        n_oldest     = r_oldest;
        n_slot       = r_slot;
        n_window     = r_window;
        n_thresh     = r_thresh;
        n_growth     = r_growth;
        n_dup_cnt    = r_dup_cnt;
        n_dup_val    = r_dup_val;
        n_hs         = r_hs;
        n_sd         = r_sd;
        n_mode       = r_mode;
        n_ack        = r_ack;
        n_run        = r_run;
        n_done_seq   = r_done_seq;
        n_rs_seq     = r_rs_seq;
        n_rs_cnt     = r_rs_cnt;
        n_rs_lim     = r_rs_lim;
        n_out_action = r_out_action;
        n_out_seq    = r_out_seq;
        n_out_win    = r_out_win;
        n_out_thr    = r_out_thr;
        n_out_last   = r_out_last;

        // latch the event, ack clipped to the highest segment sent
        if (i_cmd.cap_in) begin
            n_mode = i_mode;
            n_ack  = (i_ack_number > r_hs) ? r_hs : i_ack_number;
        end

        // apply the event to the connection state and pick the run
        if (i_cmd.decide) begin
            n_run      = cwc_pkg::RUN_NONE;
            n_done_seq = '0;
            n_rs_seq   = r_oldest;
            n_rs_cnt   = '0;
            n_rs_lim   = r_window;
            case (r_mode)
                cwc_pkg::MODE_START: begin
                    n_window  = start_win;
                    n_thresh  = start_thr;
                    n_acked   = '0;
                    n_oldest  = cwc_pkg::SEQ_W'(1);
                    n_growth  = '0;
                    n_dup_cnt = '0;
                    n_dup_val = '0;
                    n_hs      = '0;
                    if (tot == '0) begin
                        n_sd   = 1'b1;
                        n_slot = '0;
                        n_run  = cwc_pkg::RUN_COMPLETE;
                    end else begin
                        n_sd   = 1'b0;
                        n_slot = cwc_pkg::SLOT_W'(start_win);
                        n_run  = cwc_pkg::RUN_SEND;
                    end
                end
                cwc_pkg::MODE_ACK: begin
                    if (active) begin
                        if (r_ack < r_oldest) begin
                            n_dup_val = r_ack;
                            n_dup_cnt = dup_next;
                            // fast retransmit
                            if (dup_next >= dup_lim) begin
                                n_run     = cwc_pkg::RUN_RESEND;
                                n_thresh  = half_win;
                                n_window  = fr_win;
                                n_growth  = r_acked;
                                n_slot    = {1'b0, r_acked} + cwc_pkg::SLOT_W'(fr_win);
                                n_dup_cnt = '0;
                            end
                        end else begin
                            n_acked   = r_ack;
                            n_oldest  = r_ack + cwc_pkg::SEQ_W'(1);
                            n_dup_cnt = '0;
                            if (r_ack >= tot) begin
                                n_slot     = '0;
                                n_sd       = 1'b1;
                                n_run      = cwc_pkg::RUN_COMPLETE;
                                n_done_seq = tot;
                            end else begin
                                if (grow) begin
                                    n_growth = r_ack;
                                end
                                n_window = ack_win;
                                n_slot   = {1'b0, r_ack} + cwc_pkg::SLOT_W'(ack_win);
                                if (!r_sd) begin
                                    n_run = cwc_pkg::RUN_SEND;
                                end
                            end
                        end
                    end
                end
                cwc_pkg::MODE_TIMEOUT: begin
                    if (active) begin
                        n_run     = cwc_pkg::RUN_RESEND;
                        n_thresh  = half_win;
                        n_window  = cwc_pkg::WIN_W'(1);
                        n_growth  = r_acked;
                        n_slot    = {1'b0, r_acked} + cwc_pkg::SLOT_W'(1);
                        n_dup_cnt = '0;
                    end
                end
                default: begin
                    n_run = cwc_pkg::RUN_NONE;
                end
            endcase
        end

        // advance the run and load the output beat
        if (i_cmd.emit) begin
            case (r_run)
                cwc_pkg::RUN_SEND: begin
                    n_hs = hs_after[cwc_pkg::SEQ_W-1:0];
                    if (hs_after >= {1'b0, tot}) begin
                        n_sd = 1'b1;
                    end
                end
                cwc_pkg::RUN_RESEND: begin
                    n_rs_seq = rs_inc[cwc_pkg::SEQ_W-1:0];
                    n_rs_cnt = rs_cnt_inc;
                end
                default: begin
                    n_rs_cnt = r_rs_cnt;
                end
            endcase
            n_out_action = beat_action;
            n_out_seq    = beat_seq;
            n_out_win    = r_window;
            n_out_thr    = r_thresh;
            n_out_last   = beat_last;
        end
    end

    // connection state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acked   <= '0;
            r_oldest  <= cwc_pkg::SEQ_W'(1);
            r_slot    <= '0;
            r_window  <= cwc_pkg::WIN_W'(1);
            r_thresh  <= cwc_pkg::WIN_W'(16);
            r_growth  <= '0;
            r_dup_cnt <= '0;
            r_dup_val <= '0;
            r_hs      <= '0;
            r_sd      <= 1'b0;
            r_run     <= cwc_pkg::RUN_NONE;
        end else begin
            r_acked   <= n_acked;
            r_oldest  <= n_oldest;
            r_slot    <= n_slot;
            r_window  <= n_window;
            r_thresh  <= n_thresh;
            r_growth  <= n_growth;
            r_dup_cnt <= n_dup_cnt;
            r_dup_val <= n_dup_val;
            r_hs      <= n_hs;
            r_sd      <= n_sd;
            r_run     <= n_run;
        end
    end

    // event, run and beat payload registers
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_ack        <= n_ack;
        r_done_seq   <= n_done_seq;
        r_rs_seq     <= n_rs_seq;
        r_rs_cnt     <= n_rs_cnt;
        r_rs_lim     <= n_rs_lim;
        r_out_action <= n_out_action;
        r_out_seq    <= n_out_seq;
        r_out_win    <= n_out_win;
        r_out_thr    <= n_out_thr;
        r_out_last   <= n_out_last;
    end

    assign o_action        = r_out_action;
    assign o_seq_number    = r_out_seq;
    assign o_window_now    = r_out_win;
    assign o_threshold_now = r_out_thr;
    assign o_last_of_run   = r_out_last;

    // state invariants
    `CWC_ASSERT_IMP(a_acked_le_sent, 1'b1, r_acked <= r_hs, "acked edge beyond highest sent")
    `CWC_ASSERT_IMP(a_window_range,
                    1'b1,
                    (r_window != '0) && (r_window <= cwc_pkg::WIN_W'(cwc_pkg::MAX_WINDOW)),
                    "window out of range")
    `CWC_ASSERT_IMP(a_slot_edge, active,
                    (r_slot == ({1'b0, r_acked} + cwc_pkg::SLOT_W'(r_window)))
                    && (r_oldest == (r_acked + cwc_pkg::SEQ_W'(1))),
                    "send window edges out of step")
    `CWC_ASSERT_NXT(a_sent_monotonic,
                    !(i_cmd.decide && (r_mode == cwc_pkg::MODE_START)),
                    r_hs >= $past(r_hs),
                    "highest sent went back without a start")

endmodule

>>> design/cwc_ctrl.sv
`include "congestion_window_controller_assert.svh"

module cwc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  cwc_pkg::t_sts i_sts,
    output cwc_pkg::t_cmd o_cmd
);

    cwc_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    // output stage can take a beat when empty or drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cwc_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            cwc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = cwc_pkg::ST_DECIDE;
                end
            end
            cwc_pkg::ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = cwc_pkg::ST_EMIT;
            end
            cwc_pkg::ST_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.beat_last) begin
                        n_state = cwc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = cwc_pkg::ST_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // a beat that is not the last one always carries a real command
    `CWC_ASSERT_IMP(a_inner_beat_real, o_cmd.emit && !i_sts.beat_last, i_sts.beat_real,
                    "filler beat in the middle of a run")

endmodule

>>> design/congestion_window_controller.sv
// Reno-style sender window controller. Events (start, ack, timeout) come in on i_evt and
// each produces a run of one or more commands on o_res, the final one flagged by
// last_of_run; a run is send-new, retransmit, transfer-complete or a single do-nothing
// beat, and every beat reports the window and threshold after the event. An event is
// latched in one cycle and applied to the connection state in the next, then the run
// sequencer issues one command per cycle through the output register while o_res is
// not stalled. A new event is taken once the last command of the previous run sits in
// the output register.
// Registers are written over the APB port, by byte address: 0 initial window,
// 4 initial threshold, 8 duplicate ack limit, 12 total segments; write them only
// between events.
`include "congestion_window_controller_assert.svh"

module congestion_window_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cwc_evt_if.sink                        i_evt,
    cwc_res_if.source                      o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cwc_pkg::ADDR_W-1:0]     paddr,
    input  logic [cwc_pkg::DATA_W-1:0]     pwdata,
    output logic [cwc_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    cwc_pkg::t_cfg r_cfg, n_cfg;
    cwc_pkg::t_cmd cmd;
    cwc_pkg::t_sts sts;
    logic          cfg_wr;
    logic          in_ready;
    logic          out_valid;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                cwc_pkg::REG_INIT_WINDOW:    n_cfg.init_window    = pwdata[cwc_pkg::WIN_W-1:0];
                cwc_pkg::REG_INIT_THRESHOLD: n_cfg.init_threshold = pwdata[cwc_pkg::WIN_W-1:0];
                cwc_pkg::REG_DUP_ACK_LIMIT:  n_cfg.dup_ack_limit  = pwdata[cwc_pkg::DUP_W-1:0];
                cwc_pkg::REG_TOTAL_SEGMENTS: n_cfg.total_segments = pwdata[cwc_pkg::SEQ_W-1:0];
                default:                     n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_window    <= cwc_pkg::WIN_W'(1);
            r_cfg.init_threshold <= cwc_pkg::WIN_W'(16);
            r_cfg.dup_ack_limit  <= cwc_pkg::DUP_W'(3);
            r_cfg.total_segments <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            cwc_pkg::REG_INIT_WINDOW:    prdata = cwc_pkg::DATA_W'(r_cfg.init_window);
            cwc_pkg::REG_INIT_THRESHOLD: prdata = cwc_pkg::DATA_W'(r_cfg.init_threshold);
            cwc_pkg::REG_DUP_ACK_LIMIT:  prdata = cwc_pkg::DATA_W'(r_cfg.dup_ack_limit);
            cwc_pkg::REG_TOTAL_SEGMENTS: prdata = cwc_pkg::DATA_W'(r_cfg.total_segments);
            default:                     prdata = '0;
        endcase
    end

    // sequencer
    cwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_evt.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // window state and command datapath
    cwc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd           (cmd),
        .i_mode          (i_evt.mode),
        .i_ack_number    (i_evt.ack_number),
        .o_sts           (sts),
        .o_action        (o_res.action),
        .o_seq_number    (o_res.seq_number),
        .o_window_now    (o_res.window_now),
        .o_threshold_now (o_res.threshold_now),
        .o_last_of_run   (o_res.last_of_run)
    );

    assign i_evt.ready = in_ready;
    assign o_res.valid = out_valid;

endmodule
